[design/gs_pkg.sv]
//------------------------------------------------------------------------------
// gs_pkg
// shared types and constants for the gauss-seidel linear solver
//------------------------------------------------------------------------------
package gs_pkg;

    localparam int VALUE_W  = 32;
    localparam int PROD_W   = 64;
    localparam int CHANGE_W = 40;
    localparam int RESULT_LIMIT = 16;

    localparam logic [1:0] FUNC_LOAD_COEF  = 2'd0;
    localparam logic [1:0] FUNC_LOAD_RIGHT = 2'd1;
    localparam logic [1:0] FUNC_LOAD_GUESS = 2'd2;
    localparam logic [1:0] FUNC_SOLVE      = 2'd3;

    localparam logic [1:0] STATUS_CONVERGED = 2'd0;
    localparam logic [1:0] STATUS_LIMIT     = 2'd1;
    localparam logic [1:0] STATUS_ZERO_DIAG = 2'd2;

    localparam logic [1:0] REG_MATRIX_SIZE = 2'd0;
    localparam logic [1:0] REG_TOLERANCE   = 2'd1;
    localparam logic [1:0] REG_MAX_SWEEPS  = 2'd2;

    // divider request and reply
    typedef struct packed {
        logic                      start;
        logic signed [PROD_W-1:0]  num;
        logic signed [VALUE_W-1:0] den;
    } div_req_t;

    typedef struct packed {
        logic                      done;
        logic signed [VALUE_W-1:0] quo;
    } div_rsp_t;

    // saturating signed 64-bit add
    function automatic logic signed [PROD_W-1:0] sat_add64(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [PROD_W-1:0] s;
        begin
            s = a + b;
            if (a[PROD_W-1] == b[PROD_W-1] && s[PROD_W-1] != a[PROD_W-1])
                s = a[PROD_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
            return s;
        end
    endfunction

    // saturating signed 64-bit subtract
    function automatic logic signed [PROD_W-1:0] sat_sub64(
        input logic signed [PROD_W-1:0] a,
        input logic signed [PROD_W-1:0] b
    );
        logic signed [PROD_W-1:0] s;
        begin
            s = a - b;
            if (a[PROD_W-1] != b[PROD_W-1] && s[PROD_W-1] != a[PROD_W-1])
                s = a[PROD_W-1] ? {1'b1, {(PROD_W-1){1'b0}}} : {1'b0, {(PROD_W-1){1'b1}}};
            return s;
        end
    endfunction

endpackage

[design/gs_divider.sv]
//------------------------------------------------------------------------------
// gs_divider
// radix-2 restoring divider, 64-bit numerator by 32-bit divisor, truncating
// toward zero, saturating the quotient to signed 32 bits
//------------------------------------------------------------------------------
module gs_divider
    import gs_pkg::*;
(
    input  logic     clk,
    input  logic     rst_n,
    input  div_req_t req,
    output div_rsp_t rsp
);

    logic [PROD_W-1:0]  rem_reg, rem_next;
    logic [PROD_W-1:0]  quo_reg, quo_next;
    logic [VALUE_W-1:0] den_reg, den_next;
    logic               neg_reg, neg_next;
    logic [6:0]         cnt_reg, cnt_next;
    logic               busy_reg, busy_next;
    logic               done_reg, done_next;

    logic [PROD_W:0]    trial;
    logic [PROD_W:0]    shifted;
    logic [VALUE_W-1:0] sat_q;

    // one quotient bit per cycle
    always_comb
    begin
        rem_next  = rem_reg;
        quo_next  = quo_reg;
        den_next  = den_reg;
        neg_next  = neg_reg;
        cnt_next  = cnt_reg;
        busy_next = busy_reg;
        done_next = 1'b0;
        shifted   = {rem_reg, quo_reg[PROD_W-1]};
        trial     = shifted - {{(PROD_W-VALUE_W+1){1'b0}}, den_reg};
        if (req.start)
        begin
            rem_next  = '0;
            quo_next  = req.num[PROD_W-1] ? (~req.num + 1'b1) : req.num;
            den_next  = req.den[VALUE_W-1] ? (~req.den + 1'b1) : req.den;
            neg_next  = req.num[PROD_W-1] ^ req.den[VALUE_W-1];
            cnt_next  = 7'd0;
            busy_next = 1'b1;
        end
        else if (busy_reg)
        begin
            if (!trial[PROD_W])
            begin
                rem_next = trial[PROD_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b1};
            end
            else
            begin
                rem_next = shifted[PROD_W-1:0];
                quo_next = {quo_reg[PROD_W-2:0], 1'b0};
            end
            cnt_next = cnt_reg + 7'd1;
            if (cnt_reg == 7'(PROD_W-1))
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg <= 1'b0;
            done_reg <= 1'b0;
            cnt_reg  <= '0;
        end
        else
        begin
            busy_reg <= busy_next;
            done_reg <= done_next;
            cnt_reg  <= cnt_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg <= rem_next;
        quo_reg <= quo_next;
        den_reg <= den_next;
        neg_reg <= neg_next;
    end

    // sign and saturation of the magnitude quotient
    always_comb
    begin
        if (!neg_reg)
            sat_q = (quo_reg > 64'h7FFF_FFFF) ? 32'h7FFF_FFFF : quo_reg[VALUE_W-1:0];
        else if (quo_reg >= 64'h8000_0000)
            sat_q = 32'h8000_0000;
        else
            sat_q = ~quo_reg[VALUE_W-1:0] + 1'b1;
    end

    assign rsp.done = done_reg;
    assign rsp.quo  = sat_q;

    ast_no_restart: assert property (@(posedge clk) disable iff (!rst_n)
        busy_reg |-> !req.start) else $error("divider restarted while busy");
    ast_done_pulse: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |=> !done_reg) else $error("divider done held");
    ast_done_idle: assert property (@(posedge clk) disable iff (!rst_n)
        done_reg |-> !busy_reg) else $error("divider done while busy");

endmodule

[design/gauss_seidel_linear_solver_unit.sv]
//------------------------------------------------------------------------------
// gauss_seidel_linear_solver_unit
// load items write one store entry each; a solve item first checks every
// diagonal (a zero one skips the sweeps), then per sweep does one memory read
// per product, one division by the shared divider per row and one sweep check,
// then gives n result beats, one per cycle. the receiver cannot stall.
// rst_n is asynchronous; control and config reset, datapath and stores do not.
//------------------------------------------------------------------------------
module gauss_seidel_linear_solver_unit
    import gs_pkg::*;
#(
    parameter int MAX_UNKNOWNS = 16
)
(
    input  logic                      clk,
    input  logic                      rst_n,
    input  logic                      start,
    output logic                      busy,
    input  logic [1:0]                func,
    input  logic [3:0]                row,
    input  logic [3:0]                col,
    input  logic signed [31:0]        value,
    input  logic                      cfg_we,
    input  logic [1:0]                cfg_index,
    input  logic [15:0]               cfg_data,
    output logic                      strobe,
    output logic [3:0]                index,
    output logic signed [31:0]        solution,
    output logic                      last,
    output logic [7:0]                sweeps,
    output logic [1:0]                status
);

    localparam int IW    = (MAX_UNKNOWNS > 1) ? $clog2(MAX_UNKNOWNS) : 1;
    localparam int NW    = $clog2(MAX_UNKNOWNS + 1);
    localparam int NMAX  = (MAX_UNKNOWNS < RESULT_LIMIT) ? MAX_UNKNOWNS : RESULT_LIMIT;

    typedef enum logic [7:0] {
        S_IDLE  = 8'b0000_0001,
        S_DIAG  = 8'b0000_0010,
        S_ROW   = 8'b0000_0100,
        S_MAC   = 8'b0000_1000,
        S_DIV   = 8'b0001_0000,
        S_WAIT  = 8'b0010_0000,
        S_CHECK = 8'b0100_0000,
        S_EMIT  = 8'b1000_0000
    } state_t;

    // configuration registers
    logic [4:0]  matrix_size_reg;
    logic [15:0] tolerance_reg;
    logic [7:0]  max_sweeps_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            matrix_size_reg <= 5'd16;
            tolerance_reg   <= 16'd7;
            max_sweeps_reg  <= 8'd51;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                REG_MATRIX_SIZE: matrix_size_reg <= cfg_data[4:0];
                REG_TOLERANCE:   tolerance_reg   <= cfg_data;
                REG_MAX_SWEEPS:  max_sweeps_reg  <= cfg_data[7:0];
                default: ;
            endcase
        end
    end

    // effective size
    logic [NW-1:0] n_eff;
    always_comb
    begin
        if (matrix_size_reg == 5'd0)
            n_eff = NW'(1);
        else if (32'(matrix_size_reg) > NMAX)
            n_eff = NW'(NMAX);
        else
            n_eff = NW'(matrix_size_reg);
    end

    // stores: coefficient memory and vector memories
    logic signed [31:0] coef_mem [2**(2*IW)];
    logic signed [31:0] rhs_mem  [MAX_UNKNOWNS];
    logic signed [31:0] x_mem    [MAX_UNKNOWNS];

    logic               coef_we;
    logic [2*IW-1:0]    coef_waddr, coef_raddr;
    logic signed [31:0] coef_rdata;
    logic               x_we;
    logic [IW-1:0]      x_waddr, x_raddr, rhs_raddr;
    logic signed [31:0] x_wdata, x_rdata, rhs_rdata;

    always_ff @(posedge clk)
    begin
        if (coef_we)
            coef_mem[coef_waddr] <= value;
        coef_rdata <= coef_mem[coef_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (start && !busy && func == FUNC_LOAD_RIGHT && 32'(row) < MAX_UNKNOWNS)
            rhs_mem[IW'(row)] <= value;
        rhs_rdata <= rhs_mem[rhs_raddr];
    end

    always_ff @(posedge clk)
    begin
        if (x_we)
            x_mem[x_waddr] <= x_wdata;
        x_rdata <= x_mem[x_raddr];
    end

    // sequencer registers
    state_t             state_reg, state_next;
    logic [IW-1:0]      i_reg, i_next;
    logic [IW-1:0]      j_reg, j_next;
    logic [NW-1:0]      k_reg, k_next;
    logic               pend_reg, pend_next;
    logic               bad_reg, bad_next;
    logic [7:0]         sweep_reg, sweep_next;
    logic [CHANGE_W-1:0] chg_reg, chg_next;
    logic signed [PROD_W-1:0] acc_reg, acc_next;
    logic signed [31:0] diag_reg, diag_next;
    logic signed [31:0] old_reg, old_next;
    logic [1:0]         stat_reg, stat_next;
    logic signed [PROD_W-1:0] prod_reg;
    logic               prod_vld_reg, prod_vld_next;
    logic               emit_vld_reg;
    logic [IW-1:0]      emit_i_reg;

    div_req_t dreq;
    div_rsp_t drsp;

    gs_divider u_div (
        .clk   (clk),
        .rst_n (rst_n),
        .req   (dreq),
        .rsp   (drsp)
    );

    function automatic logic [IW-1:0] wrap_inc(input logic [IW-1:0] v, input logic [NW-1:0] n);
        logic [NW:0] s;
        begin
            s = {1'b0, NW'(v)} + 1'b1;
            return (s >= {1'b0, n}) ? '0 : s[IW-1:0];
        end
    endfunction

    logic signed [32:0] diff;
    logic [32:0]        mag;
    logic [CHANGE_W:0]  chg_sum;

    assign diff    = 33'(old_reg) - 33'($signed(drsp.quo));
    assign mag     = diff[32] ? (~diff + 1'b1) : diff;
    assign chg_sum = {1'b0, chg_reg} + (CHANGE_W+1)'(mag);

    // main sequencer
    always_comb
    begin
        state_next    = state_reg;
        i_next        = i_reg;
        j_next        = j_reg;
        k_next        = k_reg;
        pend_next     = 1'b0;
        bad_next      = bad_reg;
        sweep_next    = sweep_reg;
        chg_next      = chg_reg;
        acc_next      = acc_reg;
        diag_next     = diag_reg;
        old_next      = old_reg;
        stat_next     = stat_reg;
        prod_vld_next = 1'b0;
        coef_we       = 1'b0;
        coef_waddr    = {IW'(row), IW'(col)};
        coef_raddr    = {i_reg, j_reg};
        x_raddr       = j_reg;
        rhs_raddr     = i_reg;
        x_we          = 1'b0;
        x_waddr       = i_reg;
        x_wdata       = drsp.quo;
        dreq.start    = 1'b0;
        dreq.num      = sat_sub64({{(PROD_W-48){rhs_rdata[31]}}, rhs_rdata, 16'd0}, acc_reg);
        dreq.den      = diag_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (start && !busy)
                begin
                    case (func)
                        FUNC_LOAD_COEF:
                            coef_we = (32'(row) < MAX_UNKNOWNS) && (32'(col) < MAX_UNKNOWNS);
                        FUNC_LOAD_GUESS:
                        begin
                            x_we    = 32'(row) < MAX_UNKNOWNS;
                            x_waddr = IW'(row);
                            x_wdata = value;
                        end
                        FUNC_SOLVE:
                        begin
                            state_next = S_DIAG;
                            i_next     = '0;
                            j_next     = '0;
                            bad_next   = 1'b0;
                            sweep_next = '0;
                            chg_next   = '0;
                        end
                        default: ;
                    endcase
                end
            end
            // read each diagonal, check the previous one
            S_DIAG:
            begin
                coef_raddr = {i_reg, i_reg};
                pend_next  = 1'b1;
                if (pend_reg && coef_rdata == 32'sd0)
                    bad_next = 1'b1;
                if (!pend_reg || 32'(i_reg) + 1 < 32'(n_eff))
                begin
                    if (pend_reg)
                        i_next = i_reg + 1'b1;
                    coef_raddr = {(pend_reg ? i_reg + 1'b1 : i_reg), (pend_reg ? i_reg + 1'b1 : i_reg)};
                end
                else
                begin
                    i_next = '0;
                    pend_next = 1'b0;
                    if (bad_reg || coef_rdata == 32'sd0)
                    begin
                        stat_next  = STATUS_ZERO_DIAG;
                        state_next = S_EMIT;
                    end
                    else
                        state_next = S_ROW;
                end
            end
            // start a row
            S_ROW:
            begin
                acc_next   = '0;
                j_next     = wrap_inc(i_reg, n_eff);
                k_next     = NW'(1);
                state_next = S_MAC;
            end
            // issue one read pair a cycle, multiply, accumulate after register
            S_MAC:
            begin
                if (pend_reg)
                    prod_vld_next = 1'b1;
                if (prod_vld_reg)
                    acc_next = sat_add64(acc_reg, prod_reg);
                if (k_reg < n_eff)
                begin
                    pend_next = 1'b1;
                    j_next    = wrap_inc(j_reg, n_eff);
                    k_next    = k_reg + 1'b1;
                end
                else if (!pend_reg && !prod_vld_reg)
                begin
                    coef_raddr = {i_reg, i_reg};
                    x_raddr    = i_reg;
                    state_next = S_DIV;
                end
            end
            // diagonal, old x and right side now readable
            S_DIV:
            begin
                diag_next  = coef_rdata;
                old_next   = x_rdata;
                state_next = S_WAIT;
                pend_next  = 1'b1;
            end
            S_WAIT:
            begin
                if (pend_reg)
                    dreq.start = 1'b1;
                if (drsp.done)
                begin
                    x_we     = 1'b1;
                    chg_next = chg_sum[CHANGE_W] ? {CHANGE_W{1'b1}} : chg_sum[CHANGE_W-1:0];
                    if (32'(i_reg) + 1 < 32'(n_eff))
                    begin
                        i_next     = i_reg + 1'b1;
                        state_next = S_ROW;
                    end
                    else
                        state_next = S_CHECK;
                end
            end
            S_CHECK:
            begin
                sweep_next = sweep_reg + 8'd1;
                i_next     = '0;
                if (chg_reg < CHANGE_W'(tolerance_reg))
                begin
                    stat_next  = STATUS_CONVERGED;
                    state_next = S_EMIT;
                end
                else if (sweep_reg + 8'd1 >= max_sweeps_reg)
                begin
                    stat_next  = STATUS_LIMIT;
                    state_next = S_EMIT;
                end
                else
                begin
                    chg_next   = '0;
                    state_next = S_ROW;
                end
            end
            // read one unknown a cycle, beat goes out next cycle
            S_EMIT:
            begin
                x_raddr   = i_reg;
                pend_next = 1'b1;
                if (32'(i_reg) + 1 < 32'(n_eff))
                    i_next = i_reg + 1'b1;
                else
                    state_next = S_IDLE;
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg    <= S_IDLE;
            i_reg        <= '0;
            j_reg        <= '0;
            k_reg        <= '0;
            pend_reg     <= 1'b0;
            bad_reg      <= 1'b0;
            sweep_reg    <= '0;
            chg_reg      <= '0;
            stat_reg     <= STATUS_CONVERGED;
            prod_vld_reg <= 1'b0;
            emit_vld_reg <= 1'b0;
            emit_i_reg   <= '0;
        end
        else
        begin
            state_reg    <= state_next;
            i_reg        <= i_next;
            j_reg        <= j_next;
            k_reg        <= k_next;
            pend_reg     <= pend_next;
            bad_reg      <= bad_next;
            sweep_reg    <= sweep_next;
            chg_reg      <= chg_next;
            stat_reg     <= stat_next;
            prod_vld_reg <= prod_vld_next;
            emit_vld_reg <= (state_reg == S_EMIT);
            emit_i_reg   <= i_reg;
        end
    end

    // datapath registers
    always_ff @(posedge clk)
    begin
        acc_reg  <= acc_next;
        diag_reg <= diag_next;
        old_reg  <= old_next;
        prod_reg <= PROD_W'(coef_rdata) * PROD_W'(x_rdata);
    end

    // result beat
    assign busy     = (state_reg != S_IDLE) || emit_vld_reg;
    assign strobe   = emit_vld_reg;
    assign index    = 4'(emit_i_reg);
    assign solution = x_rdata;
    assign last     = emit_vld_reg && (32'(emit_i_reg) + 1 == 32'(n_eff));
    assign sweeps   = sweep_reg;
    assign status   = stat_reg;

    ast_no_beat_idle: assert property (@(posedge clk) disable iff (!rst_n)
        strobe |-> $past(state_reg) == S_EMIT) else $error("beat outside emit");
    ast_last_ends: assert property (@(posedge clk) disable iff (!rst_n)
        (strobe && last) |=> !strobe) else $error("beat after last");
    ast_sweep_bound: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> (sweep_reg < max_sweeps_reg || sweep_reg == 8'd0))
        else $error("sweep beyond limit");
    ast_diag_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_ROW) |-> !bad_reg) else $error("sweep with zero diagonal");

endmodule
